// ----- rtl/pcns_pkg.sv -----
package pcns_pkg;

  // Field widths of the stream payloads.
  localparam int COORD_W     = 16;
  localparam int ATTR_W      = 32;
  localparam int RADIUS_W    = 16;
  localparam int CMD_W       = 2;
  localparam int PIDX_W      = 6;
  localparam int PROD_W      = 2 * COORD_W;
  localparam int DIST_W      = PROD_W + 2;
  localparam int PT_W        = 3 * COORD_W + ATTR_W;
  localparam int IN_TDATA_W  = 96;
  localparam int OUT_TDATA_W = 120;

  // Default store capacity.
  localparam int POINTS_DEF = 64;

  typedef enum logic [CMD_W-1:0] {
    CMD_CLEAR   = 2'd0,
    CMD_APPEND  = 2'd1,
    CMD_NEAREST = 2'd2,
    CMD_RADIUS  = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_FETCH,
    S_DIFF,
    S_MUL,
    S_PUSH,
    S_FINAL
  } state_t;

endpackage

// ----- rtl/point_cloud_neighbor_search.sv -----
// Channel | Role   | Ports                                     | Item
// --------+--------+-------------------------------------------+---------------------------------
// in_     | slave  | tvalid tready tdata[95:0] tuser[1:0]      | clear, append or query command
// out_    | master | tvalid tready tdata[119:0] tuser[0] tlast | one reported point of a query
//
// Clear and append are taken while idle. In the fetch state a query squares the radius and
// reads point zero; each point then passes through the axis differences, the axis squares on
// the shared 16x16 squarer and the sum and compare, and the final item is loaded last. Each
// radius match after the first is pushed out in its own state, and an empty store goes straight
// to the final item. A full, untaken output register stalls the scan at the next match or at the
// final item. rst_n is synchronous and active low and empties the store; in_tready is high only
// while no query is in progress.
module point_cloud_neighbor_search #(
  parameter int POINTS = pcns_pkg::POINTS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // in_tdata, low to high: coord_x[15:0], coord_y[31:16], coord_z[47:32],
  // attribute[79:48], radius[95:80]
  input  logic [pcns_pkg::IN_TDATA_W-1:0]    in_tdata,
  // in_tuser: cmd[1:0]
  input  logic [pcns_pkg::CMD_W-1:0]         in_tuser,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // out_tdata, low to high: point_index[5:0], out_x[21:6], out_y[37:22], out_z[53:38],
  // out_attribute[85:54], distance_sq[119:86]
  output logic [pcns_pkg::OUT_TDATA_W-1:0]   out_tdata,
  // out_tuser: found[0]
  output logic                               out_tuser,
  output logic                               out_tlast
);
  import pcns_pkg::*;

  localparam int IDX_W = (POINTS > 1) ? $clog2(POINTS) : 1;
  localparam int CNT_W = $clog2(POINTS + 1);

  state_t state_r, state_nxt;

  // Input fields.
  cmd_t                  in_cmd;
  logic [COORD_W-1:0]    in_x, in_y, in_z;
  logic [ATTR_W-1:0]     in_attr;
  logic [RADIUS_W-1:0]   in_radius;
  logic                  in_acc;

  assign in_cmd    = cmd_t'(in_tuser);
  assign in_x      = in_tdata[15:0];
  assign in_y      = in_tdata[31:16];
  assign in_z      = in_tdata[47:32];
  assign in_attr   = in_tdata[79:48];
  assign in_radius = in_tdata[95:80];
  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;

  // Point store: {attribute, z, y, x} per entry.
  logic [PT_W-1:0]  mem [POINTS];
  logic [PT_W-1:0]  rd_q_r;
  logic [IDX_W-1:0] rd_addr;

  logic [CNT_W-1:0] cnt_r;
  logic [CNT_W-1:0] idx_r;
  logic [CNT_W-1:0] idx_inc;

  // Query operands.
  logic [COORD_W-1:0]  qx_r, qy_r, qz_r;
  logic [RADIUS_W-1:0] rad_r;
  logic                q_radius_r;
  logic [PROD_W-1:0]   r2_r;

  // Distance unit.
  logic [PT_W-1:0]    pt_r;
  logic [COORD_W-1:0] dx_r, dy_r, dz_r;
  logic [1:0]         ax_r;
  logic [COORD_W-1:0] mul_a;
  logic [PROD_W-1:0]  mul_p;
  logic [PROD_W-1:0]  prod_r;
  logic [DIST_W-1:0]  acc_r;
  logic [DIST_W-1:0]  dist_sum;

  // Candidate held back until its successor or the end of the scan is known.
  logic               have_r;
  logic [PT_W-1:0]    hold_pt_r;
  logic [IDX_W-1:0]   hold_idx_r;
  logic [DIST_W-1:0]  hold_dist_r;

  logic better, match, take, push_need, more;

  // Output register.
  logic                   out_valid_r;
  logic [OUT_TDATA_W-1:0] out_tdata_r;
  logic                   out_tuser_r;
  logic                   out_tlast_r;
  logic                   out_free;
  logic                   out_load;
  logic                   load_found;
  logic [OUT_TDATA_W-1:0] load_tdata;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;
  assign out_tlast  = out_tlast_r;
  assign out_free   = !out_valid_r || out_tready;

  assign idx_inc = idx_r + CNT_W'(1);
  assign rd_addr = (state_r == S_FETCH) ? idx_r[IDX_W-1:0] : idx_inc[IDX_W-1:0];
  assign more    = (idx_inc < cnt_r);

  // Absolute difference of two signed Q8.8 values always fits in 16 unsigned bits.
  function automatic logic [COORD_W-1:0] abs_diff(input logic [COORD_W-1:0] a,
                                                  input logic [COORD_W-1:0] b);
    logic [COORD_W:0] d;
    logic [COORD_W:0] m;
    d = {a[COORD_W-1], a} - {b[COORD_W-1], b};
    m = d[COORD_W] ? (~d + (COORD_W+1)'(1)) : d;
    return m[COORD_W-1:0];
  endfunction

  // The one squarer: radius in the fetch cycle, one axis per cycle during the scan.
  always_comb begin
    mul_a = rad_r;
    if (state_r == S_MUL) begin
      unique case (ax_r)
        2'd0:    mul_a = dx_r;
        2'd1:    mul_a = dy_r;
        default: mul_a = dz_r;
      endcase
    end
  end
  assign mul_p = mul_a * mul_a;

  // Sum of the last square with the running total, and the decision for this point.
  assign dist_sum  = acc_r + DIST_W'(prod_r);
  assign better    = !have_r || (dist_sum < hold_dist_r);
  assign match     = (dist_sum <= DIST_W'(r2_r));
  assign take      = q_radius_r ? match : better;
  assign push_need = q_radius_r && match && have_r;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc && (in_cmd == CMD_NEAREST || in_cmd == CMD_RADIUS)) begin
          state_nxt = (cnt_r == '0) ? S_FINAL : S_FETCH;
        end
      end
      S_FETCH: state_nxt = S_DIFF;
      S_DIFF:  state_nxt = S_MUL;
      S_MUL: begin
        if (ax_r == 2'd3) begin
          if (push_need) begin
            state_nxt = S_PUSH;
          end else if (more) begin
            state_nxt = S_DIFF;
          end else begin
            state_nxt = S_FINAL;
          end
        end
      end
      S_PUSH: begin
        if (out_free) begin
          state_nxt = more ? S_DIFF : S_FINAL;
        end
      end
      S_FINAL: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Result loading: a pushed match is never the last one; the final item reports the
  // held candidate, or nothing found when there is none.
  always_comb begin
    out_load   = (state_r == S_PUSH || state_r == S_FINAL) && out_free;
    load_found = (state_r == S_PUSH) || have_r;
    load_tdata = '0;
    if (load_found) begin
      load_tdata = {hold_dist_r, hold_pt_r[79:48], hold_pt_r[47:32], hold_pt_r[31:16],
                    hold_pt_r[15:0], PIDX_W'(hold_idx_r)};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && in_cmd == CMD_APPEND && cnt_r < CNT_W'(POINTS)) begin
      mem[cnt_r[IDX_W-1:0]] <= {in_attr, in_z, in_y, in_x};
    end
    rd_q_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      have_r      <= 1'b0;
      ax_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_acc) begin
        unique case (in_cmd)
          CMD_CLEAR: cnt_r <= '0;
          CMD_APPEND: begin
            if (cnt_r < CNT_W'(POINTS)) begin
              cnt_r <= cnt_r + CNT_W'(1);
            end
          end
          default: have_r <= 1'b0;
        endcase
      end
      if (state_r == S_DIFF) begin
        ax_r <= '0;
      end else if (state_r == S_MUL) begin
        ax_r <= ax_r + 2'd1;
      end
      if (state_r == S_MUL && ax_r == 2'd3 && take && !push_need) begin
        have_r <= 1'b1;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      qx_r       <= in_x;
      qy_r       <= in_y;
      qz_r       <= in_z;
      rad_r      <= in_radius;
      q_radius_r <= (in_cmd == CMD_RADIUS);
      idx_r      <= '0;
    end
    unique case (state_r)
      S_FETCH: r2_r <= mul_p;
      S_DIFF: begin
        pt_r <= rd_q_r;
        dx_r <= abs_diff(rd_q_r[15:0], qx_r);
        dy_r <= abs_diff(rd_q_r[31:16], qy_r);
        dz_r <= abs_diff(rd_q_r[47:32], qz_r);
      end
      S_MUL: begin
        if (ax_r != 2'd3) begin
          prod_r <= mul_p;
          acc_r  <= (ax_r == 2'd0) ? '0 : dist_sum;
        end else begin
          acc_r <= dist_sum;
          if (take && !push_need) begin
            hold_pt_r   <= pt_r;
            hold_idx_r  <= idx_r[IDX_W-1:0];
            hold_dist_r <= dist_sum;
          end
          if (!push_need && more) begin
            idx_r <= idx_inc;
          end
        end
      end
      S_PUSH: begin
        if (out_free) begin
          hold_pt_r   <= pt_r;
          hold_idx_r  <= idx_r[IDX_W-1:0];
          hold_dist_r <= acc_r;
          if (more) begin
            idx_r <= idx_inc;
          end
        end
      end
      default: begin
      end
    endcase
    if (out_load) begin
      out_tdata_r <= load_tdata;
      out_tuser_r <= load_found;
      out_tlast_r <= (state_r == S_FINAL);
    end
  end

endmodule
